### rtl/frapx_pkg.sv
// Shared types and constants for the Farey rational approximation block.
package frapx_pkg;

  localparam int unsigned MAX_ITER_DEFAULT = 100;
  localparam logic [31:0] MAX_DEN_RESET    = 32'd1048575;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_OOR,
    CMD_DIV_LIM,
    CMD_SET_LIM,
    CMD_MUL_TB,
    CMD_SET_DLO,
    CMD_MUL_TD,
    CMD_SET_DHI,
    CMD_MUL_DLO_D,
    CMD_SAVE_TMP,
    CMD_MUL_DHI_B,
    CMD_PICK_FINAL,
    CMD_MUL_TBD,
    CMD_SET_SIDE,
    CMD_PICK_SIDE,
    CMD_DIV_N,
    CMD_SET_N,
    CMD_MUL_NB,
    CMD_DIV_CUT,
    CMD_MUL_NA,
    CMD_ADVANCE
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LIM_W,
    ST_TB,
    ST_TB_W,
    ST_TD,
    ST_TD_W,
    ST_TEST,
    ST_F1_W,
    ST_F2,
    ST_F2_W,
    ST_MED_W,
    ST_GUARD,
    ST_N_W,
    ST_NB,
    ST_NB_W,
    ST_OVER,
    ST_CUT_W,
    ST_NB2,
    ST_NB2_W,
    ST_NA,
    ST_NA_W,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic is_neg;
    logic is_above;
    logic stop;
    logic guard;
    logic over;
  } status_t;

endpackage

### rtl/frapx_mul.sv
// 64x64 multiplier, product modulo 2^64, built from one 32x32 multiplier used in turn for each partial product.
module frapx_mul
  import frapx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] x_r, y_r, pp_r, acc_r;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;
  logic [31:0] mx, my;
  logic [63:0] pp_nxt;

  always_comb begin
    case (ph_r)
      2'd0:    begin mx = x_r[31:0];  my = y_r[31:0];  end
      2'd1:    begin mx = x_r[63:32]; my = y_r[31:0];  end
      default: begin mx = x_r[31:0];  my = y_r[63:32]; end
    endcase
    pp_nxt = 64'(mx) * 64'(my);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // cross terms only reach the upper word
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
    end else if (busy_r) begin
      pp_r <= pp_nxt;
      case (ph_r)
        2'd0:    acc_r <= acc_r;
        2'd1:    acc_r <= pp_r;
        default: acc_r <= acc_r + {pp_r[31:0], 32'd0};
      endcase
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

### rtl/frapx_div.sv
// 64-bit restoring divider, one quotient bit per cycle.
module frapx_div
  import frapx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem_r, quo_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'd0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/frapx_dp.sv
// Datapath: interval endpoints, distances, run length and result registers.
module frapx_dp
  import frapx_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [33:0] target,
  input  logic [31:0] cfg_max,
  output status_t     status,
  output logic [31:0] numerator,
  output logic [31:0] denominator,
  output logic [6:0]  iteration_count,
  output logic        out_of_range
);

  localparam int IIW = $clog2(MAX_ITERATIONS + 2);

  logic [33:0]    t_r;
  logic [63:0]    m_r, lim_r, a_r, b_r, c_r, d_r, dlo_r, dhi_r, n_r, tmp_r;
  logic           side_r;
  logic [IIW-1:0] ii_r;
  logic [31:0]    num_r, den_r;
  logic [6:0]     cnt_r;
  logic           oor_r;

  logic           mul_start, mul_done, div_start, div_done;
  logic [63:0]    mx, my, mul_p, dn, dd, div_q;
  logic [63:0]    t64, bd, ac, moved;
  logic [IIW+6:0] ii_ext;

  assign t64   = {30'd0, t_r};
  assign bd    = b_r + d_r;
  assign ac    = a_r + c_r;
  assign moved = side_r ? d_r : b_r;
  assign ii_ext = {7'd0, ii_r};

  always_comb begin
    mul_start = 1'b1;
    mx = n_r;
    my = side_r ? b_r : d_r;
    case (cmd)
      CMD_MUL_TB:    begin mx = t64;   my = b_r; end
      CMD_MUL_TD:    begin mx = t64;   my = d_r; end
      CMD_MUL_TBD:   begin mx = t64;   my = bd;  end
      CMD_MUL_DLO_D: begin mx = dlo_r; my = d_r; end
      CMD_MUL_DHI_B: begin mx = dhi_r; my = b_r; end
      CMD_MUL_NB:    begin mx = n_r;   my = side_r ? b_r : d_r; end
      CMD_MUL_NA:    begin mx = n_r;   my = side_r ? a_r : c_r; end
      default:       mul_start = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    dn = side_r ? dhi_r : dlo_r;
    dd = side_r ? dlo_r : dhi_r;
    case (cmd)
      CMD_DIV_LIM: begin
        dn = 64'h0000_0000_FFFF_FFFF;
        dd = (m_r << 3) + (m_r << 1);
      end
      CMD_DIV_N: begin
        dn = side_r ? dhi_r : dlo_r;
        dd = side_r ? dlo_r : dhi_r;
      end
      CMD_DIV_CUT: begin
        dn = m_r - moved;
        dd = side_r ? b_r : d_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  frapx_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .p     (mul_p)
  );

  frapx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dn),
    .den   (dd),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        t_r    <= target;
        m_r    <= (cfg_max == 32'd0) ? 64'd1 : {32'd0, cfg_max};
        a_r    <= 64'd0;
        b_r    <= 64'd1;
        c_r    <= 64'd1;
        d_r    <= 64'd1;
        ii_r   <= '0;
      end
      CMD_OOR: begin
        num_r <= t_r[33] ? 32'd0 : 32'd1;
        den_r <= 32'd1;
        cnt_r <= 7'd0;
        oor_r <= 1'b1;
      end
      CMD_SET_LIM:  lim_r <= div_q;
      CMD_SET_DLO:  dlo_r <= mul_p - {a_r[31:0], 32'd0};
      CMD_SET_DHI:  dhi_r <= {c_r[31:0], 32'd0} - mul_p;
      CMD_SAVE_TMP: tmp_r <= mul_p;
      CMD_SET_SIDE: side_r <= mul_p < {ac[31:0], 32'd0};
      CMD_SET_N:    n_r <= div_q;
      CMD_PICK_FINAL: begin
        num_r <= (tmp_r < mul_p) ? a_r[31:0] : c_r[31:0];
        den_r <= (tmp_r < mul_p) ? b_r[31:0] : d_r[31:0];
        cnt_r <= ii_ext[6:0];
        oor_r <= 1'b0;
      end
      CMD_PICK_SIDE: begin
        num_r <= side_r ? a_r[31:0] : c_r[31:0];
        den_r <= side_r ? b_r[31:0] : d_r[31:0];
        cnt_r <= ii_ext[6:0];
        oor_r <= 1'b0;
      end
      CMD_ADVANCE: begin
        if (side_r) begin
          c_r <= c_r + mul_p;
          d_r <= d_r + tmp_r;
        end else begin
          a_r <= a_r + mul_p;
          b_r <= b_r + tmp_r;
        end
        ii_r <= ii_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.is_neg   = t_r[33];
    status.is_above = !t_r[33] && t_r[32] && (t_r[31:0] != 32'd0);
    status.stop     = (bd > m_r) || (ii_r > IIW'(MAX_ITERATIONS));
    status.guard    = side_r ? (dlo_r <= lim_r) : (dhi_r <= lim_r);
    status.over     = (moved + mul_p) > m_r;
  end

  assign numerator       = num_r;
  assign denominator     = den_r;
  assign iteration_count = cnt_r;
  assign out_of_range    = oor_r;

endmodule

### rtl/frapx_ctrl.sv
// Controller: sequences the search rounds and the channel handshakes.
module frapx_ctrl
  import frapx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (status.is_neg || status.is_above) ? ST_OUT : ST_LIM_W;
      ST_LIM_W: if (status.div_done) state_nxt = ST_TB;
      ST_TB:    state_nxt = ST_TB_W;
      ST_TB_W:  if (status.mul_done) state_nxt = ST_TD;
      ST_TD:    state_nxt = ST_TD_W;
      ST_TD_W:  if (status.mul_done) state_nxt = ST_TEST;
      ST_TEST:  state_nxt = status.stop ? ST_F1_W : ST_MED_W;
      ST_F1_W:  if (status.mul_done) state_nxt = ST_F2;
      ST_F2:    state_nxt = ST_F2_W;
      ST_F2_W:  if (status.mul_done) state_nxt = ST_OUT;
      ST_MED_W: if (status.mul_done) state_nxt = ST_GUARD;
      ST_GUARD: state_nxt = status.guard ? ST_OUT : ST_N_W;
      ST_N_W:   if (status.div_done) state_nxt = ST_NB;
      ST_NB:    state_nxt = ST_NB_W;
      ST_NB_W:  if (status.mul_done) state_nxt = ST_OVER;
      ST_OVER:  state_nxt = status.over ? ST_CUT_W : ST_NA;
      ST_CUT_W: if (status.div_done) state_nxt = ST_NB2;
      ST_NB2:   state_nxt = ST_NB2_W;
      ST_NB2_W: if (status.mul_done) state_nxt = ST_NA;
      ST_NA:    state_nxt = ST_NA_W;
      ST_NA_W:  if (status.mul_done) state_nxt = ST_TB;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = CMD_NOP;
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE:  if (in_valid) cmd = CMD_LOAD;
      ST_CHECK: cmd = (status.is_neg || status.is_above) ? CMD_OOR : CMD_DIV_LIM;
      ST_LIM_W: if (status.div_done) cmd = CMD_SET_LIM;
      ST_TB:    cmd = CMD_MUL_TB;
      ST_TB_W:  if (status.mul_done) cmd = CMD_SET_DLO;
      ST_TD:    cmd = CMD_MUL_TD;
      ST_TD_W:  if (status.mul_done) cmd = CMD_SET_DHI;
      ST_TEST:  cmd = status.stop ? CMD_MUL_DLO_D : CMD_MUL_TBD;
      ST_F1_W:  if (status.mul_done) cmd = CMD_SAVE_TMP;
      ST_F2:    cmd = CMD_MUL_DHI_B;
      ST_F2_W:  if (status.mul_done) cmd = CMD_PICK_FINAL;
      ST_MED_W: if (status.mul_done) cmd = CMD_SET_SIDE;
      ST_GUARD: cmd = status.guard ? CMD_PICK_SIDE : CMD_DIV_N;
      ST_N_W:   if (status.div_done) cmd = CMD_SET_N;
      ST_NB:    cmd = CMD_MUL_NB;
      ST_OVER:  cmd = status.over ? CMD_DIV_CUT : CMD_SAVE_TMP;
      ST_CUT_W: if (status.div_done) cmd = CMD_SET_N;
      ST_NB2:   cmd = CMD_MUL_NB;
      ST_NB2_W: if (status.mul_done) cmd = CMD_SAVE_TMP;
      ST_NA:    cmd = CMD_MUL_NA;
      ST_NA_W:  if (status.mul_done) cmd = CMD_ADVANCE;
      default:  cmd = CMD_NOP;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_load_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted item did not start range check");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");
  a_round_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_ADVANCE) |=> (state_r == ST_TB))
    else $error("round advance did not restart distance pass");
`endif

endmodule

### rtl/farey_rational_approximation.sv
// Top level: Farey best rational approximation with APB configuration.
//
//  channel | signals                                   | transfer when
//  in      | in_valid, in_ready, in_target[33:0]       | in_valid & in_ready
//  out     | out_valid, out_ready, numerator/denom/... | out_valid & out_ready
//  cfg     | psel, penable, pwrite, paddr, pwdata      | psel & penable & pwrite
//
// One item at a time. Setup runs the guard-limit division; each round uses the shared
// multiplier and the bit-serial divider, with one more division and multiply when the
// run is cut at the maximum; up to MAX_ITERATIONS+1 rounds. Out-of-range targets skip
// the search after the range check. Reset is synchronous, active low, and
// loads max_denominator with 1048575. A held result stalls the next input.
module farey_rational_approximation
  import frapx_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [33:0] in_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_numerator,
  output logic [31:0] out_denominator,
  output logic [6:0]  out_iteration_count,
  output logic        out_out_of_range,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] max_den_r;
  status_t     status;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_den_r <= MAX_DEN_RESET;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      max_den_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = max_den_r;

  frapx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  frapx_dp #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .target          (in_target),
    .cfg_max         (max_den_r),
    .status          (status),
    .numerator       (out_numerator),
    .denominator     (out_denominator),
    .iteration_count (out_iteration_count),
    .out_of_range    (out_out_of_range)
  );

endmodule

### tb/tb.sv
// Testbench for the Farey rational approximation block: queue-fed driver, checking monitor.
module tb;
  import frapx_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic [6:0]  iters;
    logic        oor;
  } fraction_t;

  localparam longint unsigned ONE_Q = 64'h1_0000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [33:0] in_target;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_numerator;
  logic [31:0] out_denominator;
  logic [6:0]  out_iteration_count;
  logic        out_out_of_range;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [33:0] pending_targets[$];
  fraction_t   expected_fracs[$];
  logic [31:0] max_den;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          errors;
  int          fracs_checked;
  int          oor_checked;
  logic        hold_req;
  logic        hold_used;
  int          hold_left;
  logic        hold_active;

  farey_rational_approximation DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_target           (in_target),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_numerator       (out_numerator),
    .out_denominator     (out_denominator),
    .out_iteration_count (out_iteration_count),
    .out_out_of_range    (out_out_of_range),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic fraction_t best_fraction(logic [33:0] tgt, logic [31:0] mx);
    fraction_t r;
    longint unsigned t, m, lim, a, b, c, d, ac, bd, dlo, dhi, n, k;
    a = 0; b = 1; c = 1; d = 1; k = 0;
    r.oor = 1'b1;
    r.iters = '0;
    r.den = 32'd1;
    if (tgt[33]) begin
      r.num = 32'd0;
      return r;
    end
    t = {30'd0, tgt};
    if (t > ONE_Q) begin
      r.num = 32'd1;
      return r;
    end
    r.oor = 1'b0;
    m = (mx == 0) ? 64'd1 : {32'd0, mx};
    lim = (ONE_Q - 1) / (64'd10 * m);
    forever begin
      ac = a + c;
      bd = b + d;
      dlo = t * b - a * ONE_Q;
      dhi = c * ONE_Q - t * d;
      if (bd > m || k > MAX_ITER_DEFAULT) begin
        if (dlo * d < dhi * b) begin r.num = a[31:0]; r.den = b[31:0]; end
        else begin r.num = c[31:0]; r.den = d[31:0]; end
        break;
      end
      if (t * bd < ac * ONE_Q) begin
        if (dlo <= lim) begin r.num = a[31:0]; r.den = b[31:0]; break; end
        n = dhi / dlo;
        if (d + n * b > m) n = (m - d) / b;
        c = c + n * a;
        d = d + n * b;
      end else begin
        if (dhi <= lim) begin r.num = c[31:0]; r.den = d[31:0]; break; end
        n = dlo / dhi;
        if (b + n * d > m) n = (m - b) / d;
        a = a + n * c;
        b = b + n * d;
      end
      k++;
    end
    r.iters = k[6:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Driver: hold the item until transfer, then offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_target <= '0;
    end else begin
      if (in_valid && in_ready) expected_fracs.push_back(best_fraction(in_target, max_den));
      if (!in_valid || in_ready) begin
        if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_target <= pending_targets.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= 20000;
      hold_used <= 1'b1;
    end
  end
  assign hold_active = (hold_left != 0);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fracs.size() == 0) begin
          report($sformatf("unexpected result %0d/%0d", out_numerator, out_denominator));
        end else begin
          fraction_t e;
          e = expected_fracs.pop_front();
          if (out_numerator !== e.num)
            report($sformatf("numerator %0d, want %0d", out_numerator, e.num));
          if (out_denominator !== e.den)
            report($sformatf("denominator %0d, want %0d", out_denominator, e.den));
          if (out_iteration_count !== e.iters)
            report($sformatf("iterations %0d, want %0d", out_iteration_count, e.iters));
          if (out_out_of_range !== e.oor)
            report($sformatf("out_of_range %0b, want %0b", out_out_of_range, e.oor));
          if (e.oor) oor_checked++;
          else fracs_checked++;
        end
      end
      out_ready <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drain();
    while (pending_targets.size() > 0 || in_valid || expected_fracs.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_max_den(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    max_den = v;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== v) report($sformatf("max_denominator reads %0d, want %0d", prdata, v));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [33:0] rand_target();
    int r;
    logic [31:0] q;
    r = $urandom_range(99);
    if (r < 8) return {2'($urandom_range(3)), 32'($urandom())};
    if (r < 14) begin
      case ($urandom_range(5))
        0: return 34'd0;
        1: return 34'h1_0000_0000;
        2: return 34'h1_0000_0001;
        3: return 34'h3_FFFF_FFFF;
        4: return 34'd1;
        default: return 34'h0_FFFF_FFFF;
      endcase
    end
    if (r < 50) begin
      // nice rationals p/q with a small q
      q = $urandom_range(1, 500);
      return 34'((64'($urandom_range(0, q)) << 32) / 64'(q));
    end
    return {2'b00, 32'($urandom())};
  endfunction

  task automatic queue_random(int count);
    repeat (count) pending_targets.push_back(rand_target());
  endtask

  initial begin
    errors = 0; fracs_checked = 0; oor_checked = 0;
    hold_req = 1'b0;
    max_den = MAX_DEN_RESET;
    send_idle_pct = 11; recv_idle_pct = 58;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range edges, out-of-range sides, deep expansions
    pending_targets.push_back(34'd0);
    pending_targets.push_back(34'h1_0000_0000);
    pending_targets.push_back(34'h1_0000_0001);
    pending_targets.push_back(34'h1_FFFF_FFFF);
    pending_targets.push_back(34'h3_FFFF_FFFF);
    pending_targets.push_back(34'h2_0000_0000);
    pending_targets.push_back(34'h0_8000_0000);
    pending_targets.push_back(34'h0_5555_5555);
    pending_targets.push_back(34'h0_243F_6A89);
    pending_targets.push_back(34'd1);
    pending_targets.push_back(34'h0_FFFF_FFFF);
    pending_targets.push_back(34'h0_9E37_79B9);
    drain();
    set_max_den(32'd0);
    pending_targets.push_back(34'h0_9E37_79B9);
    pending_targets.push_back(34'h0_8000_0000);
    pending_targets.push_back(34'h0_C000_0000);
    drain();
    set_max_den(32'hFFFF_FFFF);
    pending_targets.push_back(34'h0_9E37_79B9);
    pending_targets.push_back(34'h0_243F_6A89);
    pending_targets.push_back(34'd1);
    pending_targets.push_back(34'h0_FFFF_FFFF);
    drain();
    set_max_den(32'd1);
    pending_targets.push_back(34'h0_4000_0000);
    pending_targets.push_back(34'h0_8000_0000);
    drain();
    set_max_den(32'd10);
    pending_targets.push_back(34'h0_243F_6A89);
    pending_targets.push_back(34'h0_9E37_79B9);
    drain();

    // random phases over several maxima
    set_max_den($urandom());
    queue_random(12);
    drain();
    set_max_den($urandom_range(1, 1000));
    hold_req = 1'b1;
    queue_random(25);
    drain();
    send_idle_pct = 58; recv_idle_pct = 11;
    set_max_den(32'hFFFF_FFFF);
    queue_random(10);
    drain();
    queue_random(10);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_max_den(32'd0);
    queue_random(10);
    drain();
    set_max_den($urandom_range(1, 1 << 20));
    queue_random(25);
    drain();
    repeat (200) @(posedge clk);

    $display("Checked %0d in-range and %0d out-of-range targets", fracs_checked, oor_checked);
    $display("over eight max_denominator settings, stalls on both sides and a long hold-off.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### farey_rational_approximation.f
rtl/frapx_pkg.sv
rtl/frapx_mul.sv
rtl/frapx_div.sv
rtl/frapx_dp.sv
rtl/frapx_ctrl.sv
rtl/farey_rational_approximation.sv
tb/tb.sv
